// ===== sv/crcdf_pkg.sv =====
package crcdf_pkg;

	localparam logic [31:0] FRAME_MAGIC   = 32'h3150_4847;
	localparam logic [15:0] FRAME_VERSION = 16'd1;
	localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
	localparam int unsigned FIELD_LEN_W   = 27;
	localparam int unsigned HDR_BYTES     = 16;
	localparam logic [FIELD_LEN_W-1:0] MAX_RESET     = 27'h400_0000;
	localparam logic [31:0]            FIELD_LEN_MAX = 32'h07FF_FFFF;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_TRAILER = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_ACCEPT  = 2'd1,
		KIND_REJECT  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_MAGIC     = 3'd1,
		ST_VERSION   = 3'd2,
		ST_TOO_LARGE = 3'd3,
		ST_CRC       = 3'd4
	} status_t;

	typedef struct packed {
		kind_t                  kind;
		logic [7:0]             data;
		logic [15:0]            opcode;
		logic [31:0]            sequence_res;
		logic [FIELD_LEN_W-1:0] payload_length;
		status_t                status;
	} res_t;

	// reflected CRC-32, one byte, bitwise unrolled
	function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
		end
		return c;
	endfunction

endpackage

// ===== sv/crc32_frame_deframer_unit.sv =====
// channel  | dir | tdata (low bit up)                                   | tuser
// s_axis   | in  | byte_in[7:0]                                         | -
// m_axis   | out | data, opcode, sequence_res, payload_length, status   | kind
// cfg_wr   | in  | max_payload_bytes[26:0] on cfg_wr_data              | -
//
// One byte is taken per cycle while s_axis_tready is high; all parsing and the bytewise
// CRC update happen in the cycle the byte is accepted, and the result word is registered.
// A two-entry output (register plus skid) lets input flow while a result waits;
// s_axis_tready drops only when both entries are full.
// arst_n clears phase, counters and the output valids, sets the CRC to CRC_INIT and the limit to MAX_RESET.
module crc32_frame_deframer_unit
	import crcdf_pkg::*;
#(
	parameter int LENGTH_BITS = 27
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // byte_in
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [87:0] m_axis_tdata,   // data, opcode, sequence_res, payload_length, status, pad
	output logic [1:0]  m_axis_tuser,   // kind
	input  logic        cfg_wr_en,
	input  logic [FIELD_LEN_W-1:0] cfg_wr_data  // max_payload_bytes
);

	localparam logic [32:0] LEN_LIMIT = (33'd1 << LENGTH_BITS) - 33'd1;

	phase_t                  ph_q, ph_d;
	logic [LENGTH_BITS-1:0]  cnt_q, cnt_d;
	logic [LENGTH_BITS-1:0]  len_q, len_d;
	logic [31:0]             crc_q, crc_d, crc_nx;
	logic [23:0]             rcv_q, rcv_d;
	logic [7:0]              hdr_q [HDR_BYTES];
	logic [7:0]              hv [HDR_BYTES];
	logic [FIELD_LEN_W-1:0]  max_q;
	logic                    hdr_we;

	logic [7:0]  b;
	logic        in_fire, out_fire, hdr_last, crc_good;
	logic [31:0] magic, seqn, len;
	logic [15:0] ver, opc;
	status_t     hdr_status;
	logic [LENGTH_BITS:0] cnt_inc;

	res_t res;
	logic res_valid;
	res_t out_q, sk_q;
	logic sk_valid_q, m_valid_q;

	assign b        = s_axis_tdata;
	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign out_fire = m_valid_q && m_axis_tready;
	assign hdr_last = (ph_q == PH_HEADER) && (cnt_q[3:0] == 4'd15);
	assign crc_nx   = crc_byte(crc_q, b);
	assign cnt_inc  = {1'b0, cnt_q} + {{LENGTH_BITS{1'b0}}, 1'b1};
	assign crc_good = (~crc_q) == {b, rcv_q};

	always_comb begin
		for (int k = 0; k < HDR_BYTES; k++) begin
			hv[k] = hdr_q[k];
		end
		if (hdr_last) begin
			hv[15] = b;
		end
	end

	assign magic = {hv[3], hv[2], hv[1], hv[0]};
	assign ver   = {hv[5], hv[4]};
	assign opc   = {hv[7], hv[6]};
	assign seqn  = {hv[11], hv[10], hv[9], hv[8]};
	assign len   = {hv[15], hv[14], hv[13], hv[12]};

	always_comb begin
		if (magic != FRAME_MAGIC) begin
			hdr_status = ST_MAGIC;
		end else if (ver != FRAME_VERSION) begin
			hdr_status = ST_VERSION;
		end else if (len > {5'd0, max_q} || {1'b0, len} > LEN_LIMIT) begin
			hdr_status = ST_TOO_LARGE;
		end else begin
			hdr_status = ST_OK;
		end
	end

	// next state
	always_comb begin
		ph_d   = ph_q;
		cnt_d  = cnt_q;
		crc_d  = crc_q;
		rcv_d  = rcv_q;
		len_d  = len_q;
		hdr_we = 1'b0;
		case (ph_q)
			PH_PAYLOAD: begin
				crc_d = crc_nx;
				if (cnt_inc >= {1'b0, len_q}) begin
					ph_d  = PH_TRAILER;
					cnt_d = '0;
				end else begin
					cnt_d = cnt_inc[LENGTH_BITS-1:0];
				end
			end
			PH_TRAILER: begin
				case (cnt_q[1:0])
					2'd0: rcv_d[7:0]   = b;
					2'd1: rcv_d[15:8]  = b;
					2'd2: rcv_d[23:16] = b;
					default: rcv_d = rcv_q;
				endcase
				if (cnt_q[1:0] == 2'd3) begin
					ph_d  = PH_HEADER;
					cnt_d = '0;
					crc_d = CRC_INIT;
				end else begin
					cnt_d = cnt_inc[LENGTH_BITS-1:0];
				end
			end
			default: begin
				hdr_we = 1'b1;
				crc_d  = crc_nx;
				if (hdr_last) begin
					cnt_d = '0;
					if (hdr_status != ST_OK) begin
						ph_d  = PH_HEADER;
						crc_d = CRC_INIT;
					end else begin
						ph_d  = (len == 32'd0) ? PH_TRAILER : PH_PAYLOAD;
						len_d = len[LENGTH_BITS-1:0];
					end
				end else begin
					cnt_d = cnt_inc[LENGTH_BITS-1:0];
				end
			end
		endcase
	end

	// result word
	always_comb begin
		res.opcode         = opc;
		res.sequence_res   = seqn;
		res.payload_length = (len > FIELD_LEN_MAX) ? FIELD_LEN_MAX[FIELD_LEN_W-1:0]
		                                           : len[FIELD_LEN_W-1:0];
		res.data   = 8'd0;
		res.kind   = KIND_REJECT;
		res.status = ST_OK;
		res_valid  = 1'b0;
		case (ph_q)
			PH_PAYLOAD: begin
				res_valid = 1'b1;
				res.kind  = KIND_PAYLOAD;
				res.data  = b;
			end
			PH_TRAILER: begin
				res_valid  = (cnt_q[1:0] == 2'd3);
				res.kind   = crc_good ? KIND_ACCEPT : KIND_REJECT;
				res.status = crc_good ? ST_OK : ST_CRC;
			end
			default: begin
				res_valid  = hdr_last && (hdr_status != ST_OK);
				res.status = hdr_status;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= PH_HEADER;
			cnt_q <= '0;
			crc_q <= CRC_INIT;
			rcv_q <= '0;
			len_q <= '0;
		end else if (in_fire) begin
			ph_q  <= ph_d;
			cnt_q <= cnt_d;
			crc_q <= crc_d;
			rcv_q <= rcv_d;
			len_q <= len_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && hdr_we) begin
			hdr_q[cnt_q[3:0]] <= b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_RESET;
		end else if (cfg_wr_en) begin
			max_q <= cfg_wr_data;
		end
	end

	// output register plus skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q  <= 1'b0;
			sk_valid_q <= 1'b0;
		end else if (sk_valid_q) begin
			if (out_fire) begin
				sk_valid_q <= 1'b0;
			end
		end else if (in_fire && res_valid) begin
			if (m_valid_q && !m_axis_tready) begin
				sk_valid_q <= 1'b1;
			end else begin
				m_valid_q <= 1'b1;
			end
		end else if (out_fire) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sk_valid_q) begin
			if (out_fire) begin
				out_q <= sk_q;
			end
		end else if (in_fire && res_valid) begin
			if (m_valid_q && !m_axis_tready) begin
				sk_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	assign s_axis_tready = !sk_valid_q;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = out_q.kind;
	assign m_axis_tdata  = {2'b00, out_q.status, out_q.payload_length, out_q.sequence_res,
	                        out_q.opcode, out_q.data};

	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		sk_valid_q |-> m_valid_q)
		else $error("skid entry full while output register empty");

	a_payload_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && ph_q == PH_PAYLOAD) |=> m_valid_q)
		else $error("payload byte produced no output word");

	a_trailer_count: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q == PH_TRAILER) |-> (cnt_q < 4))
		else $error("trailer count out of range");

	a_header_count: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q == PH_HEADER) |-> (cnt_q < HDR_BYTES))
		else $error("header count out of range");

endmodule

// ===== tb/tb_crc32_frame_deframer_unit.sv =====
`timescale 1ns / 1ps

module tb_crc32_frame_deframer_unit;
	import crcdf_pkg::*;

	localparam int LEN_BITS       = 27;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef enum int {
		F_GOOD,
		F_BAD_CRC,
		F_BAD_MAGIC,
		F_BAD_VERSION,
		F_TOO_LARGE,
		F_NOISE
	} frame_kind_t;

	class frame_scoreboard;
		res_t                   expected_words[$];
		logic [FIELD_LEN_W-1:0] max_len;
		longint unsigned        count_max;
		phase_t                 ph;
		int unsigned            sect_cnt;
		logic [7:0]             hdr[16];
		logic [31:0]            crc;
		logic [31:0]            rx_crc;
		int unsigned            errors, n_payload, n_accept, n_reject;

		function new(longint unsigned cmax);
			foreach (hdr[i]) hdr[i] = 8'h00;
			count_max = cmax;
			max_len   = MAX_RESET;
			errors    = 0;
			n_payload = 0;
			n_accept  = 0;
			n_reject  = 0;
			restart();
		endfunction

		static function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
			logic [31:0] r;
			r = c ^ {24'h0, b};
			for (int k = 0; k < 8; k++) begin
				r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
			end
			return r;
		endfunction

		function void restart();
			ph       = PH_HEADER;
			sect_cnt = 0;
			crc      = CRC_INIT;
			rx_crc   = 32'h0;
		endfunction

		function void add_expected(res_t w);
			expected_words.insert(expected_words.size(), w);
		endfunction

		function logic [31:0] hdr_le(int at, int n);
			logic [31:0] v;
			v = 32'h0;
			for (int k = 0; k < n; k++) begin
				v |= {24'h0, hdr[at + k]} << (8 * k);
			end
			return v;
		endfunction

		function res_t make_word(kind_t k, logic [7:0] d, status_t s);
			res_t        w;
			logic [31:0] len;
			len              = hdr_le(12, 4);
			w.kind           = k;
			w.data           = d;
			w.opcode         = 16'(hdr_le(6, 2));
			w.sequence_res   = hdr_le(8, 4);
			w.payload_length = FIELD_LEN_W'((len > FIELD_LEN_MAX) ? FIELD_LEN_MAX : len);
			w.status         = s;
			return w;
		endfunction

		function void note_byte(logic [7:0] b);
			logic [31:0] len;
			status_t     st;
			case (ph)
				PH_PAYLOAD: begin
					crc = crc_step(crc, b);
					sect_cnt++;
					add_expected(make_word(KIND_PAYLOAD, b, ST_OK));
					if (sect_cnt >= hdr_le(12, 4)) begin
						ph       = PH_TRAILER;
						sect_cnt = 0;
					end
				end
				PH_TRAILER: begin
					rx_crc |= {24'h0, b} << (8 * (sect_cnt % 4));
					sect_cnt++;
					if (sect_cnt >= 4) begin
						if (~crc == rx_crc)
							add_expected(make_word(KIND_ACCEPT, 8'h00, ST_OK));
						else
							add_expected(make_word(KIND_REJECT, 8'h00, ST_CRC));
						restart();
					end
				end
				default: begin
					if (ph != PH_HEADER)
						restart();
					hdr[sect_cnt % 16] = b;
					crc = crc_step(crc, b);
					sect_cnt++;
					if (sect_cnt == HDR_BYTES) begin
						len = hdr_le(12, 4);
						if (hdr_le(0, 4) != FRAME_MAGIC)
							st = ST_MAGIC;
						else if (hdr_le(4, 2) != 32'(FRAME_VERSION))
							st = ST_VERSION;
						else if (len > 32'(max_len) || 64'(len) > count_max)
							st = ST_TOO_LARGE;
						else
							st = ST_OK;
						if (st != ST_OK) begin
							add_expected(make_word(KIND_REJECT, 8'h00, st));
							restart();
						end else begin
							ph       = (len == 0) ? PH_TRAILER : PH_PAYLOAD;
							sect_cnt = 0;
						end
					end
				end
			endcase
		endfunction

		function void check_word(res_t got);
			res_t want;
			if (expected_words.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected word: kind=%0d data=%h op=%h seq=%h len=%h st=%0d",
						got.kind, got.data, got.opcode, got.sequence_res,
						got.payload_length, got.status);
				return;
			end
			want = expected_words.pop_front();
			if (got.kind != want.kind || got.data != want.data || got.opcode != want.opcode ||
					got.sequence_res != want.sequence_res ||
					got.payload_length != want.payload_length || got.status != want.status) begin
				errors++;
				if (errors <= 10) begin
					$display("mismatch: exp kind=%0d data=%h op=%h seq=%h len=%h st=%0d",
						want.kind, want.data, want.opcode, want.sequence_res,
						want.payload_length, want.status);
					$display("          got kind=%0d data=%h op=%h seq=%h len=%h st=%0d",
						got.kind, got.data, got.opcode, got.sequence_res,
						got.payload_length, got.status);
				end
			end else begin
				case (want.kind)
					KIND_PAYLOAD: n_payload++;
					KIND_ACCEPT:  n_accept++;
					default:      n_reject++;
				endcase
			end
		endfunction
	endclass

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [7:0]             s_axis_tdata  = 8'h00;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [87:0]            m_axis_tdata;
	logic [1:0]             m_axis_tuser;
	logic                   cfg_wr_en     = 1'b0;
	logic [FIELD_LEN_W-1:0] cfg_wr_data   = '0;

	frame_scoreboard sb;
	bit              steady       = 1'b0;
	bit              hold_req     = 1'b0;
	int unsigned     bytes_sent   = 0;
	int unsigned     stall_cycles = 0;
	int unsigned     cfg_writes   = 0;

	crc32_frame_deframer_unit #(
		.LENGTH_BITS(LEN_BITS)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin : monitor
		res_t got;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				sb.note_byte(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) begin
				got.kind           = kind_t'(m_axis_tuser);
				got.data           = m_axis_tdata[7:0];
				got.opcode         = m_axis_tdata[23:8];
				got.sequence_res   = m_axis_tdata[55:24];
				got.payload_length = m_axis_tdata[82:56];
				got.status         = status_t'(m_axis_tdata[85:83]);
				sb.check_word(got);
			end
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
				$display("tb_crc32_frame_deframer_unit: FAIL");
				$finish;
			end
		end
	end

	// receiver: random stalls, or one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				hold_req = 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				m_axis_tready <= steady || ($urandom_range(99) >= 11);
			end
		end
	end

	task automatic push_byte(input logic [7:0] b);
		if (!steady) begin
			while ($urandom_range(99) < 11) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		bytes_sent++;
	endtask

	// header, then optionally payload and trailer; fill < 0 means random payload
	task automatic send_frame(input logic [31:0] magic, input logic [15:0] ver,
			input logic [15:0] op, input logic [31:0] seq, input logic [31:0] len,
			input bit body, input logic [31:0] crc_flip, input int fill);
		logic [127:0] hbits;
		logic [31:0]  crc;
		logic [7:0]   b;
		hbits = {len, seq, op, ver, magic};
		crc   = CRC_INIT;
		for (int k = 0; k < 16; k++) begin
			b   = hbits[8*k +: 8];
			crc = frame_scoreboard::crc_step(crc, b);
			push_byte(b);
		end
		if (!body)
			return;
		for (longint i = 0; i < len; i++) begin
			b   = (fill < 0) ? 8'($urandom) : 8'(fill);
			crc = frame_scoreboard::crc_step(crc, b);
			push_byte(b);
		end
		crc = ~crc ^ crc_flip;
		for (int k = 0; k < 4; k++) begin
			push_byte(crc[8*k +: 8]);
		end
	endtask

	task automatic write_max(input logic [FIELD_LEN_W-1:0] v);
		s_axis_tvalid <= 1'b0;
		while (sb.expected_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		sb.max_len = v;
		cfg_wr_en <= 1'b0;
		cfg_writes++;
	endtask

	task automatic send_random_frame(input int cap);
		frame_kind_t fk;
		int unsigned r;
		logic [31:0] magic, len, lim, flip;
		logic [15:0] ver;
		r = $urandom_range(99);
		if (r < 62)      fk = F_GOOD;
		else if (r < 72) fk = F_BAD_CRC;
		else if (r < 80) fk = F_BAD_MAGIC;
		else if (r < 87) fk = F_BAD_VERSION;
		else if (r < 94) fk = F_TOO_LARGE;
		else             fk = F_NOISE;
		magic = FRAME_MAGIC;
		ver   = FRAME_VERSION;
		lim   = (32'(sb.max_len) < cap) ? 32'(sb.max_len) : cap;
		len   = $urandom_range(lim, 0);
		flip  = 32'h0;
		case (fk)
			F_BAD_CRC:
				flip = $urandom_range(1) ? (32'h1 << $urandom_range(31)) : ($urandom | 32'h1);
			F_BAD_MAGIC:
				magic = $urandom_range(1) ? (magic ^ (32'h1 << $urandom_range(31))) : $urandom;
			F_BAD_VERSION: begin
				ver = 16'($urandom);
				if (ver == FRAME_VERSION)
					ver = 16'h0000;
			end
			F_TOO_LARGE: begin
				case ($urandom_range(2))
					0:       len = 32'(sb.max_len) + 1;
					1:       len = 32'hFFFF_FFFF;
					default: len = $urandom_range(32'hFFFF_FFFF, 32'(sb.max_len) + 1);
				endcase
			end
			default: ;
		endcase
		if (fk == F_NOISE) begin
			for (int k = 0; k < 16; k++) begin
				push_byte(8'($urandom));
			end
		end else begin
			send_frame(magic, ver, 16'($urandom), $urandom, len,
				fk == F_GOOD || fk == F_BAD_CRC, flip, -1);
		end
	endtask

	task automatic run_phase(input int unsigned nbytes, input bit with_pressure);
		int unsigned stop_at, nframes;
		stop_at = bytes_sent + nbytes;
		nframes = 0;
		while (bytes_sent < stop_at) begin
			if (with_pressure) begin
				steady = (nframes >= 2 && nframes < 8);
				if (nframes == 1) begin
					hold_req = 1'b1;
					send_frame(FRAME_MAGIC, FRAME_VERSION, 16'($urandom), $urandom, 48, 1,
						32'h0, -1);
				end
			end
			send_random_frame(($urandom_range(9) == 0) ? 40 : 12);
			nframes++;
		end
		steady = 1'b0;
	endtask

	initial begin
		sb = new((64'd1 << LEN_BITS) - 1);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty payload, field extremes, each rejection reason
		send_frame(FRAME_MAGIC, FRAME_VERSION, 16'h0000, 32'h0000_0000, 0, 1, 32'h0, -1);
		send_frame(FRAME_MAGIC, FRAME_VERSION, 16'hFFFF, 32'hFFFF_FFFF, 1, 1, 32'h0, 8'hFF);
		send_frame(FRAME_MAGIC, FRAME_VERSION, 16'($urandom), $urandom, 3, 1, 32'h0, 8'h00);
		send_frame(FRAME_MAGIC, FRAME_VERSION, 16'($urandom), $urandom, 5, 1, 32'h8000_0000, -1);
		send_frame(FRAME_MAGIC ^ 32'h0100_0000, FRAME_VERSION, 16'h1234, $urandom, 4, 0, 32'h0, -1);
		send_frame(FRAME_MAGIC, 16'h0000, 16'h5678, $urandom, 4, 0, 32'h0, -1);
		send_frame(FRAME_MAGIC, 16'h0100, 16'h9ABC, $urandom, 4, 0, 32'h0, -1);
		send_frame(FRAME_MAGIC, FRAME_VERSION, 16'($urandom), $urandom, 32'h0400_0001, 0,
			32'h0, -1);
		send_frame(FRAME_MAGIC, FRAME_VERSION, 16'($urandom), $urandom, 32'h0800_0000, 0,
			32'h0, -1);
		send_frame(FRAME_MAGIC, FRAME_VERSION, 16'($urandom), $urandom, 32'hFFFF_FFFF, 0,
			32'h0, -1);

		// length limit boundary
		write_max(27'd8);
		send_frame(FRAME_MAGIC, FRAME_VERSION, 16'($urandom), $urandom, 8, 1, 32'h0, -1);
		send_frame(FRAME_MAGIC, FRAME_VERSION, 16'($urandom), $urandom, 9, 0, 32'h0, -1);
		write_max(27'd0);
		send_frame(FRAME_MAGIC, FRAME_VERSION, 16'($urandom), $urandom, 0, 1, 32'h0, -1);
		send_frame(FRAME_MAGIC, FRAME_VERSION, 16'($urandom), $urandom, 1, 0, 32'h0, -1);

		// random traffic under several limits
		write_max(MAX_RESET);
		run_phase(200, 1'b1);
		write_max(27'h3FF_FFFF);
		run_phase(90, 1'b0);
		write_max(27'($urandom_range(48, 5)));
		run_phase(90, 1'b0);
		write_max(27'($urandom_range(32'h0400_0000, 0)));
		run_phase(90, 1'b0);

		s_axis_tvalid <= 1'b0;
		while (sb.expected_words.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("run: %0d bytes sent, %0d limit writes, one long output hold-off",
			bytes_sent, cfg_writes);
		$display("results: %0d payload words, %0d frames accepted, %0d rejected, %0d errors",
			sb.n_payload, sb.n_accept, sb.n_reject, sb.errors);
		if (sb.errors == 0 && sb.expected_words.size() == 0)
			$display("tb_crc32_frame_deframer_unit: PASS");
		else
			$display("tb_crc32_frame_deframer_unit: FAIL");
		$finish;
	end

endmodule
